FILE: hdl/spq_pkg.sv
// Shared types and codes for the stable priority queue with removal.
// No dependencies; used by every module of the block.
package spq_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_FIND   = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] patient_id;
    logic [7:0]  severity;
    logic [31:0] arrival_time;
    logic [6:0]  read_position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  position;
    logic [15:0] out_id;
    logic [7:0]  out_severity;
    logic [31:0] out_arrival;
    logic [6:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  sev;
    logic [31:0] arr;
  } entry_t;

endpackage

FILE: hdl/spq_mem.sv
// Single-port-write, single-port-read entry memory with registered read data.
// Depends on spq_pkg for the entry type.
module spq_mem import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  input  entry_t                         wr_data,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  output entry_t                         rd_data
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/spq_ctrl.sv
// Request sequencer: walks the entry memory to insert, remove, find and read.
// Depends on spq_pkg; drives the memory ports of spq_mem.
module spq_ctrl import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           req_valid,
  input  in_item_t                       req_item,
  output logic                           busy,
  output logic                           res_valid,
  output out_item_t                      res_item,
  input  logic                           res_ready,
  output logic                           wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  output entry_t                         wr_data,
  output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  input  entry_t                         rd_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_SCN_RD  = 4'd3;
  localparam logic [3:0] S_SCN_CMP = 4'd4;
  localparam logic [3:0] S_SHF_RD  = 4'd5;
  localparam logic [3:0] S_SHF_WR  = 4'd6;
  localparam logic [3:0] S_RDP_RD  = 4'd7;
  localparam logic [3:0] S_RDP_CMP = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  in_item_t      req_r, req_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  entry_t        ent_r, ent_nxt;
  entry_t        new_ent;
  logic          goes_after;

  assign new_ent = '{id: req_r.patient_id, sev: req_r.severity, arr: req_r.arrival_time};
  // The stored entry sorts strictly behind the new one.
  assign goes_after = (rd_data.sev < req_r.severity) ||
                      ((rd_data.sev == req_r.severity) && (rd_data.arr > req_r.arrival_time));

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    fill_nxt  = fill_r;
    req_nxt   = req_r;
    stat_nxt  = stat_r;
    pos_nxt   = pos_r;
    ent_nxt   = ent_r;
    wr_en     = 1'b0;
    wr_addr   = cur_r[AW-1:0];
    wr_data   = rd_data;
    rd_addr   = cur_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          req_nxt  = req_item;
          stat_nxt = ST_OK;
          pos_nxt  = '0;
          ent_nxt  = '0;
          if (req_item.req_type == REQ_INSERT) begin
            if (fill_r == CW'(QUEUE_DEPTH)) begin
              stat_nxt  = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              cur_nxt   = fill_r;
              state_nxt = S_INS_RD;
            end
          end else if (fill_r == '0) begin
            stat_nxt  = ST_EMPTY;
            state_nxt = S_DONE;
          end else if (req_item.req_type == REQ_READ) begin
            if ((req_item.read_position == 7'd0) ||
                (32'(req_item.read_position) > 32'(fill_r))) begin
              stat_nxt  = ST_NOTFOUND;
              state_nxt = S_DONE;
            end else begin
              cur_nxt   = CW'(32'(req_item.read_position) - 32'd1);
              state_nxt = S_RDP_RD;
            end
          end else begin
            cur_nxt   = '0;
            state_nxt = S_SCN_RD;
          end
        end
      end
      S_INS_RD: begin
        rd_addr = AW'(cur_r - CW'(1));
        if (cur_r == '0) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          wr_data   = new_ent;
          pos_nxt   = CW'(1);
          ent_nxt   = new_ent;
          fill_nxt  = fill_r + CW'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (goes_after) begin
          // Move the entry one slot back and keep walking towards the head.
          cur_nxt   = cur_r - CW'(1);
          state_nxt = S_INS_RD;
        end else begin
          wr_data   = new_ent;
          pos_nxt   = cur_r + CW'(1);
          ent_nxt   = new_ent;
          fill_nxt  = fill_r + CW'(1);
          state_nxt = S_DONE;
        end
      end
      S_SCN_RD: begin
        if (cur_r == fill_r) begin
          stat_nxt  = ST_NOTFOUND;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCN_CMP;
        end
      end
      S_SCN_CMP: begin
        if (rd_data.id == req_r.patient_id) begin
          pos_nxt   = cur_r + CW'(1);
          ent_nxt   = rd_data;
          state_nxt = (req_r.req_type == REQ_REMOVE) ? S_SHF_RD : S_DONE;
        end else begin
          cur_nxt   = cur_r + CW'(1);
          state_nxt = S_SCN_RD;
        end
      end
      S_SHF_RD: begin
        rd_addr = AW'(cur_r + CW'(1));
        if ((cur_r + CW'(1)) >= fill_r) begin
          fill_nxt  = fill_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        wr_en     = 1'b1;
        cur_nxt   = cur_r + CW'(1);
        state_nxt = S_SHF_RD;
      end
      S_RDP_RD: begin
        state_nxt = S_RDP_CMP;
      end
      S_RDP_CMP: begin
        pos_nxt   = cur_r + CW'(1);
        ent_nxt   = rd_data;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
    cur_r  <= cur_nxt;
    req_r  <= req_nxt;
    stat_r <= stat_nxt;
    pos_r  <= pos_nxt;
    ent_r  <= ent_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_item  = '{status:       stat_r,
                       position:     7'(pos_r),
                       out_id:       ent_r.id,
                       out_severity: ent_r.sev,
                       out_arrival:  ent_r.arr,
                       occupancy:    7'(fill_r)};

endmodule

FILE: hdl/stable_priority_queue_with_removal_unit.sv
// Top level of the stable priority queue with removal.
// Depends on spq_pkg, spq_mem and spq_ctrl.
//
// Usage: requests arrive on the in_ channel (in_valid, in_stall, in_item) and
// each produces exactly one result item on the out_ channel (out_valid,
// out_stall, out_item). An item moves when valid is high and stall is low.
// Entries are held in one memory in queue order, highest severity first and
// earlier arrival first within a severity; an insert goes behind equal entries.
// One request is handled at a time; in_stall stays high while it is worked on.
// Work per request, from acceptance to the result being presented:
//   failed request (full, empty, out of range): no walk of the memory
//   read position: one read of the addressed slot
//   insert: walks from the tail towards the head, moving each entry that sorts
//     behind the new one a slot back, then writes the new entry in its slot
//   find: scans from the head until the id matches or the entries run out
//   remove: the find, then shifts each later entry one slot towards the head
// The entry memory has registered read data: each compare or shift step
// reads an entry and then acts on it in the next cycle.
// The result sits in an output register; if the receiver stalls, the result
// waits there and the sequencer holds its finished item until it can move on.
// Reset empties the queue at once; the memory contents are not cleared.
module stable_priority_queue_with_removal_unit import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic          busy;
  logic          res_valid;
  logic          res_ready;
  out_item_t     res_item;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  entry_t        wr_data;
  entry_t        rd_data;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r;

  spq_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  spq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_item  (in_item),
    .busy      (busy),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_ready (res_ready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // The output register can take a new result when it is empty or draining.
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_ready) begin
      out_item_r <= res_item;
    end
  end

  assign in_stall  = busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: hdl/spq_checker.sv
// Port-level checks for the stable priority queue with removal.
// Depends on spq_pkg; bound to stable_priority_queue_with_removal_unit.
module spq_checker import spq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another was in progress");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != ST_OK)) |->
    ((out_item.position == 7'd0) && (out_item.out_id == 16'd0) &&
     (out_item.out_severity == 8'd0) && (out_item.out_arrival == 32'd0)))
    else $error("failed request carries entry data");

  a_ok_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == ST_OK)) |-> (out_item.position != 7'd0))
    else $error("successful request without a position");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind stable_priority_queue_with_removal_unit spq_checker u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
